// ===== rtl/lmmb_pkg.sv =====
// Shared types and constants for the median/MAD binarizer.
package lmmb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ROW_W      = 16;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_WIN_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN    = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOUND,
        ST_FILL_RD,
        ST_FILL_HR,
        ST_FILL_WR,
        ST_SCAN,
        ST_MID,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } sel_ctrl_t;

endpackage

// ===== rtl/lmmb_ring_mem.sv =====
// Pixel line store: one write port and one registered read port.
module lmmb_ring_mem #(
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    logic [7:0] mem [1 << ADDR_W];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/lmmb_hist_mem.sv =====
// Level histogram: 256 bins with per-bin valid bits and two registered read ports.
module lmmb_hist_mem #(
    parameter int CNT_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clr,
    input  logic             we,
    input  logic [7:0]       waddr,
    input  logic [CNT_W-1:0] wdata,
    input  logic [7:0]       raddr_a,
    input  logic [7:0]       raddr_b,
    output logic [CNT_W-1:0] rdata_a,
    output logic [CNT_W-1:0] rdata_b
);
    logic [CNT_W-1:0] mem [256];
    logic [CNT_W-1:0] rda_reg;
    logic [CNT_W-1:0] rdb_reg;
    logic             hv_reg [256];
    logic             va_reg;
    logic             vb_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rda_reg <= mem[raddr_a];
        rdb_reg <= mem[raddr_b];
    end

    // A bin that has not been written since the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 256; i++)
            begin
                hv_reg[i] <= 1'b0;
            end
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                for (int i = 0; i < 256; i++)
                begin
                    hv_reg[i] <= 1'b0;
                end
            end
            else if (we)
            begin
                hv_reg[waddr] <= 1'b1;
            end
            va_reg <= hv_reg[raddr_a];
            vb_reg <= hv_reg[raddr_b];
        end
    end

    assign rdata_a = va_reg ? rda_reg : '0;
    assign rdata_b = vb_reg ? rdb_reg : '0;
endmodule

// ===== rtl/lmmb_select.sv =====
// Shared rank-selection unit: accumulates bin counts and picks the middle level(s).
module lmmb_select #(
    parameter int CNT_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lmmb_pkg::sel_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    cnt,
    input  logic [7:0]          level,
    input  logic [CNT_W-1:0]    kth,
    input  logic                pair,
    output logic [7:0]          result,
    output logic                found
);
    import lmmb_pkg::*;

    logic [CNT_W-1:0] acc_reg;
    logic [CNT_W-1:0] acc_next;
    logic [7:0]       a_reg;
    logic [7:0]       b_reg;
    logic             fa_reg;
    logic             fb_reg;
    logic [8:0]       pair_sum;

    assign acc_next = acc_reg + cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            a_reg   <= '0;
            b_reg   <= '0;
            fa_reg  <= 1'b0;
            fb_reg  <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
            fa_reg  <= 1'b0;
            fb_reg  <= 1'b0;
        end
        else if (ctrl.step)
        begin
            acc_reg <= acc_next;
            if (!fa_reg && acc_next > kth)
            begin
                a_reg  <= level;
                fa_reg <= 1'b1;
            end
            // The lower middle value is the first level whose running count reaches kth.
            if (!fb_reg && acc_next >= kth)
            begin
                b_reg  <= level;
                fb_reg <= 1'b1;
            end
        end
    end

    assign pair_sum = {1'b0, a_reg} + {1'b0, b_reg};
    assign result   = pair ? pair_sum[8:1] : a_reg;
    assign found    = fa_reg;
endmodule

// ===== rtl/local_median_mad_binarizer.sv =====
// Top level: counters, line store, histogram and the sequencer around the shared selection unit.
// A beat that releases a result runs the fill states ST_FILL_RD, ST_FILL_HR and ST_FILL_WR once
// per pixel of the clipped window (up to 225 pixels at a 15-pixel window), then two histogram
// scans; a beat that releases no result leaves the block idle. The block takes one beat at a
// time: in_stall holds off new beats until the sequencer is back in idle. Reset clears the counters, the
// histogram valid bits and the output slot, and loads width 1024, height 1, window 3.
module local_median_mad_binarizer #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_WIN   = 15
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lmmb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmmb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [7:0]                      pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            is_white,
    output logic                            frame_end
);
    import lmmb_pkg::*;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int W_W      = $clog2(MAX_WIDTH + 1);
    localparam int XS_W     = COL_W + 1;
    localparam int ROW_BITS = $clog2(MAX_WIN + 1);
    localparam int ADDR_W   = ROW_BITS + COL_W;
    localparam int LIM      = (MAX_WIN - 1) | 1;
    localparam int HALF_MAX = LIM / 2;
    localparam int HALF_W   = $clog2(HALF_MAX + 1);
    localparam int N_MAX    = LIM * LIM;
    localparam int N_W      = $clog2(N_MAX + 1);
    localparam int LAG_MAX  = HALF_MAX * MAX_WIDTH + HALF_MAX;
    localparam int PEND_W   = $clog2(LAG_MAX + 1);
    localparam int LF_W     = HALF_W + W_W + 1;

    state_t                state_reg, state_next;
    logic [CFG_WID_W-1:0]  width_reg, width_next;
    logic [ROW_W-1:0]      height_reg, height_next;
    logic [CFG_WIN_W-1:0]  win_reg, win_next;
    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [ROW_W-1:0]      in_row_reg, in_row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic [ROW_W-1:0]      cy_reg, cy_next;
    logic [COL_W-1:0]      cx_reg, cx_next;
    logic                  fe_reg, fe_next;
    logic [ROW_W-1:0]      yy_reg, yy_next;
    logic [ROW_W-1:0]      y1_reg, y1_next;
    logic [COL_W-1:0]      xx_reg, xx_next;
    logic [COL_W-1:0]      x0_reg, x0_next;
    logic [COL_W-1:0]      x1_reg, x1_next;
    logic [N_W-1:0]        n_reg, n_next;
    logic [7:0]            bin_reg, bin_next;
    logic [7:0]            p_reg, p_next;
    logic [8:0]            idx_reg, idx_next;
    logic                  phase_reg, phase_next;
    logic [7:0]            med_reg, med_next;
    logic                  ra_ok_reg, ra_ok_next;
    logic                  rb_ok_reg, rb_ok_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  white_reg, white_next;
    logic                  out_fe_reg, out_fe_next;

    logic [W_W-1:0]        w_eff;
    logic [ROW_W-1:0]      h_eff;
    logic [4:0]            side;
    logic [HALF_W-1:0]     half;
    logic [LF_W-1:0]       lag_full;
    logic [PEND_W-1:0]     lag;
    logic                  in_done;

    logic                  ring_we;
    logic [ADDR_W-1:0]     ring_waddr;
    logic [ADDR_W-1:0]     ring_raddr;
    logic [7:0]            ring_rdata;

    logic                  hist_clr;
    logic                  hist_we;
    logic [7:0]            hist_waddr;
    logic [N_W-1:0]        hist_wdata;
    logic [7:0]            hist_raddr_a;
    logic [7:0]            hist_raddr_b;
    logic [N_W-1:0]        hist_rdata_a;
    logic [N_W-1:0]        hist_rdata_b;

    sel_ctrl_t             sel_ctrl;
    logic [N_W-1:0]        sel_cnt;
    logic [7:0]            sel_level;
    logic [N_W-1:0]        sel_kth;
    logic                  sel_pair;
    logic [7:0]            sel_result;
    logic                  sel_found;

    logic [ROW_W:0]        ysum;
    logic [XS_W-1:0]       xsum;
    logic [XS_W-1:0]       wm1;
    logic [8:0]            med_plus;
    logic [9:0]            lhs;
    logic [9:0]            rhs;
    logic [N_W:0]          cnt_sum;

    // Effective frame geometry and window half-size.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = W_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
        side  = {1'b0, win_reg};
        if (!side[0])
        begin
            side = side + 5'd1;
        end
        if (side < 5'd3)
        begin
            side = 5'd3;
        end
        if (int'(side) > LIM)
        begin
            side = 5'(LIM);
        end
        half = HALF_W'(side >> 1);
    end

    assign lag_full = LF_W'(half) * LF_W'(w_eff) + LF_W'(half);
    assign lag      = PEND_W'(lag_full);
    assign in_done  = in_row_reg >= h_eff;
    assign sel_kth  = n_reg >> 1;
    assign sel_pair = !n_reg[0] && (sel_kth != '0);

    lmmb_ring_mem #(
        .ADDR_W(ADDR_W)
    ) u_ring (
        .clk  (clk),
        .we   (ring_we),
        .waddr(ring_waddr),
        .wdata(pixel),
        .raddr(ring_raddr),
        .rdata(ring_rdata)
    );

    lmmb_hist_mem #(
        .CNT_W(N_W)
    ) u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .clr    (hist_clr),
        .we     (hist_we),
        .waddr  (hist_waddr),
        .wdata  (hist_wdata),
        .raddr_a(hist_raddr_a),
        .raddr_b(hist_raddr_b),
        .rdata_a(hist_rdata_a),
        .rdata_b(hist_rdata_b)
    );

    lmmb_select #(
        .CNT_W(N_W)
    ) u_select (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sel_ctrl),
        .cnt   (sel_cnt),
        .level (sel_level),
        .kth   (sel_kth),
        .pair  (sel_pair),
        .result(sel_result),
        .found (sel_found)
    );

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        win_next       = win_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        pend_next      = pend_reg;
        cy_next        = cy_reg;
        cx_next        = cx_reg;
        fe_next        = fe_reg;
        yy_next        = yy_reg;
        y1_next        = y1_reg;
        xx_next        = xx_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        n_next         = n_reg;
        bin_next       = bin_reg;
        p_next         = p_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        med_next       = med_reg;
        ra_ok_next     = ra_ok_reg;
        rb_ok_next     = rb_ok_reg;
        out_valid_next = out_valid_reg;
        white_next     = white_reg;
        out_fe_next    = out_fe_reg;

        ring_we      = 1'b0;
        ring_waddr   = {in_row_reg[ROW_BITS-1:0], in_col_reg};
        ring_raddr   = {yy_reg[ROW_BITS-1:0], xx_reg};
        hist_clr     = 1'b0;
        hist_we      = 1'b0;
        hist_waddr   = bin_reg;
        hist_wdata   = hist_rdata_a + N_W'(1);
        hist_raddr_a = ring_rdata;
        hist_raddr_b = '0;
        sel_ctrl     = '{clear: 1'b0, step: 1'b0};
        cnt_sum      = (ra_ok_reg ? {1'b0, hist_rdata_a} : '0)
                     + (rb_ok_reg ? {1'b0, hist_rdata_b} : '0);
        sel_cnt      = N_W'(cnt_sum);
        sel_level    = 8'(idx_reg - 9'd1);

        ysum     = {1'b0, cy_reg} + (ROW_W + 1)'(half);
        xsum     = XS_W'(cx_reg) + XS_W'(half);
        wm1      = XS_W'(w_eff - W_W'(1));
        med_plus = {1'b0, med_reg} + {1'b0, idx_reg[7:0]};
        lhs      = {1'b0, p_reg, 1'b0};
        rhs      = {1'b0, med_reg, 1'b0} + 10'(sel_result);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:
                begin
                    width_next = cfg_data[CFG_WID_W-1:0];
                end
                REG_HEIGHT:
                begin
                    height_next = cfg_data[ROW_W-1:0];
                end
                REG_WIN:
                begin
                    win_next = cfg_data[CFG_WIN_W-1:0];
                end
                default:
                begin
                end
            endcase
            if (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_WIN})
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                pend_next    = '0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_PIXEL && !in_done)
                    begin
                        ring_we = 1'b1;
                        if (W_W'(in_col_reg) == w_eff - W_W'(1))
                        begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            in_col_next = in_col_reg + COL_W'(1);
                        end
                        // A pixel beat that finds the pending count at or above the lag releases one result.
                        if (pend_reg >= lag)
                        begin
                            state_next = ST_BOUND;
                        end
                        else
                        begin
                            pend_next = pend_reg + PEND_W'(1);
                        end
                    end
                    else if (req_type == REQ_FLUSH && in_done)
                    begin
                        state_next = ST_BOUND;
                        pend_next  = pend_reg - PEND_W'(1);
                    end
                    if (state_next == ST_BOUND)
                    begin
                        cy_next = out_row_reg;
                        cx_next = out_col_reg;
                        fe_next = (out_row_reg == h_eff - ROW_W'(1))
                               && (W_W'(out_col_reg) == w_eff - W_W'(1));
                        if (W_W'(out_col_reg) == w_eff - W_W'(1))
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            out_col_next = out_col_reg + COL_W'(1);
                        end
                        if (fe_next)
                        begin
                            in_col_next  = '0;
                            in_row_next  = '0;
                            out_col_next = '0;
                            out_row_next = '0;
                            pend_next    = '0;
                        end
                    end
                end
            end
            ST_BOUND:
            begin
                hist_clr = 1'b1;
                sel_ctrl = '{clear: 1'b1, step: 1'b0};
                n_next   = '0;
                yy_next  = (cy_reg >= ROW_W'(half)) ? cy_reg - ROW_W'(half) : '0;
                y1_next  = (ysum > {1'b0, h_eff - ROW_W'(1)}) ? h_eff - ROW_W'(1)
                                                             : ysum[ROW_W-1:0];
                xx_next  = (cx_reg >= COL_W'(half)) ? cx_reg - COL_W'(half) : '0;
                x0_next  = xx_next;
                x1_next  = (xsum > wm1) ? COL_W'(wm1) : COL_W'(xsum);
                state_next = ST_FILL_RD;
            end
            ST_FILL_RD:
            begin
                state_next = ST_FILL_HR;
            end
            ST_FILL_HR:
            begin
                bin_next = ring_rdata;
                if (yy_reg == cy_reg && xx_reg == cx_reg)
                begin
                    p_next = ring_rdata;
                end
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                hist_we = 1'b1;
                n_next  = n_reg + N_W'(1);
                if (xx_reg == x1_reg)
                begin
                    xx_next = x0_reg;
                    if (yy_reg == y1_reg)
                    begin
                        idx_next   = '0;
                        phase_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        yy_next    = yy_reg + ROW_W'(1);
                        state_next = ST_FILL_RD;
                    end
                end
                else
                begin
                    xx_next    = xx_reg + COL_W'(1);
                    state_next = ST_FILL_RD;
                end
            end
            ST_SCAN:
            begin
                // The first pass reads bin d; the deviation pass reads bins med+d and med-d.
                if (!phase_reg)
                begin
                    hist_raddr_a = idx_reg[7:0];
                    ra_ok_next   = 1'b1;
                    rb_ok_next   = 1'b0;
                end
                else
                begin
                    hist_raddr_a = med_plus[7:0];
                    hist_raddr_b = med_reg - idx_reg[7:0];
                    ra_ok_next   = !med_plus[8];
                    rb_ok_next   = (med_reg >= idx_reg[7:0]) && (idx_reg[7:0] != 8'd0);
                end
                if (idx_reg != 9'd0)
                begin
                    sel_ctrl = '{clear: 1'b0, step: 1'b1};
                end
                idx_next = idx_reg + 9'd1;
                if (idx_reg[8])
                begin
                    state_next = phase_reg ? ST_OUT : ST_MID;
                end
            end
            ST_MID:
            begin
                med_next   = sel_result;
                phase_next = 1'b1;
                idx_next   = '0;
                sel_ctrl   = '{clear: 1'b1, step: 1'b0};
                state_next = ST_SCAN;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    white_next     = lhs >= rhs;
                    out_fe_next    = fe_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= CFG_WID_W'(1024);
            height_reg    <= ROW_W'(1);
            win_reg       <= CFG_WIN_W'(3);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pend_reg      <= '0;
            cy_reg        <= '0;
            cx_reg        <= '0;
            fe_reg        <= 1'b0;
            yy_reg        <= '0;
            y1_reg        <= '0;
            xx_reg        <= '0;
            x0_reg        <= '0;
            x1_reg        <= '0;
            n_reg         <= '0;
            bin_reg       <= '0;
            p_reg         <= '0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            med_reg       <= '0;
            ra_ok_reg     <= 1'b0;
            rb_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            white_reg     <= 1'b0;
            out_fe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            win_reg       <= win_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            pend_reg      <= pend_next;
            cy_reg        <= cy_next;
            cx_reg        <= cx_next;
            fe_reg        <= fe_next;
            yy_reg        <= yy_next;
            y1_reg        <= y1_next;
            xx_reg        <= xx_next;
            x0_reg        <= x0_next;
            x1_reg        <= x1_next;
            n_reg         <= n_next;
            bin_reg       <= bin_next;
            p_reg         <= p_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            med_reg       <= med_next;
            ra_ok_reg     <= ra_ok_next;
            rb_ok_reg     <= rb_ok_next;
            out_valid_reg <= out_valid_next;
            white_reg     <= white_next;
            out_fe_reg    <= out_fe_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_white  = white_reg;
    assign frame_end = out_fe_reg;

    // The window never holds more pixels than the largest square allows.
    assert property (@(posedge clk) disable iff (!rst_n) n_reg <= N_W'(N_MAX))
        else $error("window pixel count out of range");

    // Both scans must have located the middle rank before a decision is made.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MID || state_reg == ST_OUT) |-> sel_found)
        else $error("rank selection ended without a result");

    // Between beats the backlog of undecided pixels stays within the lag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (pend_reg <= lag))
        else $error("pending pixel count exceeds the lag");

    // A result is only loaded into the output slot once the previous beat has gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && out_stall) |=> (state_reg == ST_OUT))
        else $error("result loaded over a waiting beat");
endmodule
